### hw/rtl/spfr_pkg.sv
// Shared types, constants and formatting helpers for the sensor poll frame relay.
`timescale 1ns / 1ps

package spfr_pkg;

   // Frame layout and channel limits.
   localparam int FRAME_BYTES  = 42;
   localparam int FRAME_ADDR_W = $clog2(FRAME_BYTES);
   localparam int MAX_CHANNELS = 4;
   localparam int CH_W         = 2;
   localparam int TICK_W       = 7;
   localparam int FMT_STEPS    = 5;
   localparam int STEP_W       = 3;

   localparam logic [TICK_W-1:0] DUMP_TICK = 7'd100;
   localparam logic [TICK_W-1:0] SERVICE_TICK [MAX_CHANNELS] = '{7'd20, 7'd40, 7'd60, 7'd80};
   localparam logic [FRAME_ADDR_W-1:0] GROUP_BASE [MAX_CHANNELS] =
      '{6'd5, 6'd14, 6'd23, 6'd32};
   localparam logic [FRAME_ADDR_W-1:0] LAST_FRAME_ADDR = 6'(FRAME_BYTES - 1);
   localparam logic [STEP_W-1:0] LAST_FMT_STEP = 3'(FMT_STEPS - 1);

   // Configuration register indexes and reset values.
   localparam logic CSR_POLL_CODE  = 1'b0;
   localparam logic CSR_PERIOD_TOP = 1'b1;
   localparam logic [7:0] POLL_CODE_RESET = 8'h55;
   localparam logic [TICK_W-1:0] PERIOD_TOP_RESET = 7'd120;

   // Request kinds and output ports.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_REPLY = 1'b1;
   localparam logic [2:0] UPSTREAM_PORT = 3'd4;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_CLAMP = 8'd99;

   // Frame contents after reset: header, four channel groups, CR LF.
   localparam logic [7:0] FRAME_TEMPLATE [FRAME_BYTES] = '{
      8'h23, 8'h44, 8'h54, 8'h55, 8'h2C,
      8'h30, 8'h31, 8'h2C, 8'h30, 8'h30, 8'h2C, 8'h30, 8'h30, 8'h2C,
      8'h30, 8'h31, 8'h2C, 8'h30, 8'h30, 8'h2C, 8'h30, 8'h30, 8'h2C,
      8'h30, 8'h31, 8'h2C, 8'h30, 8'h30, 8'h2C, 8'h30, 8'h30, 8'h2C,
      8'h30, 8'h31, 8'h2C, 8'h30, 8'h30, 8'h2C, 8'h30, 8'h30,
      8'h0D, 8'h0A
   };

   typedef enum logic {
      CMD_POLL,
      CMD_DUMP
   } cmd_kind_type;

   // One classified work command from the front to the back.
   typedef struct packed {
      cmd_kind_type    kind;
      logic [CH_W-1:0] channel;
      logic            fmt;
      logic [7:0]      presence;
      logic [7:0]      temperature;
      logic [7:0]      humidity;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FMT,
      BK_POLL,
      BK_DUMP_RD,
      BK_DUMP_WR
   } back_state_type;

   // Clamp to 99 and return {tens, ones} as ASCII digits.
   function automatic logic [15:0] digit_pair(input logic [7:0] v);
      logic [6:0]  c;
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      c    = (v > DIGIT_CLAMP) ? 7'd99 : v[6:0];
      prod = 14'(c) * 14'd103;
      tens = prod[13:10];
      ones = c - 7'(7'(tens) * 7'd10);
      return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
   endfunction

endpackage

### hw/rtl/spfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/spfr_front.sv
// Front end: accepts beats, keeps the tick counter and reply store, issues commands.
`timescale 1ns / 1ps

module spfr_front import spfr_pkg::*; #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [CH_W-1:0]   req_channel,
   input  logic [7:0]        req_presence_byte,
   input  logic [7:0]        req_temperature_byte,
   input  logic [7:0]        req_humidity_byte,
   input  logic [TICK_W-1:0] period_top,
   output logic              cmd_push,
   output cmd_type           cmd_data,
   input  logic              cmd_full
);

   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [MAX_CHANNELS-1:0] reply_ready_ff, reply_ready_in;
   logic [23:0] reply_bytes_ff [MAX_CHANNELS];

   logic [TICK_W-1:0] tick_next;
   logic [MAX_CHANNELS-1:0] svc_hit;
   logic [CH_W-1:0] svc_ch;
   logic svc_any;
   logic dump_hit;
   logic accept;
   logic is_tick;
   logic reply_ok;

   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_type == REQ_TICK);
   assign reply_ok  = (req_type == REQ_REPLY) && (32'(req_channel) < NUM_CHANNELS);

   // Counter advance, wrapping to zero only at the programmed top.
   assign tick_next = (tick_count_ff == period_top) ? '0 : tick_count_ff + 7'd1;
   assign dump_hit  = (tick_next == DUMP_TICK);

   // Find the channel whose service tick this is.
   always_comb begin
      svc_ch = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         svc_hit[c] = (c < NUM_CHANNELS) && (tick_next == SERVICE_TICK[c]);
         if (svc_hit[c]) begin
            svc_ch = CH_W'(c);
         end
      end
      svc_any = |svc_hit;
   end

   // Command toward the back end.
   always_comb begin
      cmd_push             = accept && is_tick && (svc_any || dump_hit);
      cmd_data.kind        = svc_any ? CMD_POLL : CMD_DUMP;
      cmd_data.channel     = svc_ch;
      cmd_data.fmt         = reply_ready_ff[svc_ch];
      cmd_data.presence    = reply_bytes_ff[svc_ch][23:16];
      cmd_data.temperature = reply_bytes_ff[svc_ch][15:8];
      cmd_data.humidity    = reply_bytes_ff[svc_ch][7:0];
   end

   // Next counter and ready flags.
   always_comb begin
      tick_count_in  = tick_count_ff;
      reply_ready_in = reply_ready_ff;
      if (accept && is_tick) begin
         tick_count_in = tick_next;
         if (svc_any) begin
            reply_ready_in[svc_ch] = 1'b0;
         end
      end
      if (accept && reply_ok) begin
         reply_ready_in[req_channel] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         reply_ready_ff <= '0;
      end else begin
         tick_count_ff  <= tick_count_in;
         reply_ready_ff <= reply_ready_in;
      end
   end

   // Reply payload store; a new reply replaces the old one.
   always_ff @(posedge clock) begin
      if (accept && reply_ok) begin
         reply_bytes_ff[req_channel] <= {req_presence_byte, req_temperature_byte,
                                         req_humidity_byte};
      end
   end

endmodule

### hw/rtl/spfr_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module spfr_queue import spfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    not_empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/spfr_back.sv
// Back end: formats replies into the frame memory, sends polls and frame dumps.
`timescale 1ns / 1ps

module spfr_back import spfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd_data,
   output logic       cmd_pop,
   input  logic [7:0] poll_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_out_port,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_last
);

   back_state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FRAME_ADDR_W-1:0] idx_ff, idx_in;
   logic [FRAME_BYTES-1:0] written_ff, written_in;
   logic rd_written_ff;
   logic [7:0] rd_tmpl_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_port_ff, rsp_port_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic rsp_load;
   logic ram_we;
   logic [FRAME_ADDR_W-1:0] ram_waddr;
   logic [7:0] ram_wdata;
   logic ram_re;
   logic [7:0] ram_rdata;
   logic [7:0] frame_byte;
   logic [15:0] temp_digits;
   logic [15:0] hum_digits;
   logic [FRAME_ADDR_W-1:0] fmt_offset;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign temp_digits = digit_pair(cmd_ff.temperature);
   assign hum_digits  = digit_pair(cmd_ff.humidity);
   assign frame_byte  = rd_written_ff ? ram_rdata : rd_tmpl_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.kind == CMD_DUMP) begin
                  state_in = BK_DUMP_RD;
               end else if (cmd_data.fmt) begin
                  state_in = BK_FMT;
               end else begin
                  state_in = BK_POLL;
               end
            end
         end
         BK_FMT: begin
            if (step_ff == LAST_FMT_STEP) begin
               state_in = BK_POLL;
            end
         end
         BK_POLL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_DUMP_RD: begin
            state_in = BK_DUMP_WR;
         end
         BK_DUMP_WR: begin
            if (out_free) begin
               state_in = (idx_ff == LAST_FRAME_ADDR) ? BK_IDLE : BK_DUMP_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Position of each formatted byte inside a channel group.
   always_comb begin
      case (step_ff)
         3'd0:    fmt_offset = 6'd1;
         3'd1:    fmt_offset = 6'd3;
         3'd2:    fmt_offset = 6'd4;
         3'd3:    fmt_offset = 6'd6;
         3'd4:    fmt_offset = 6'd7;
         default: fmt_offset = 6'd0;
      endcase
   end

   // Byte written at each formatting step.
   always_comb begin
      case (step_ff)
         3'd0:    ram_wdata = cmd_ff.presence + ASCII_ZERO;
         3'd1:    ram_wdata = temp_digits[15:8];
         3'd2:    ram_wdata = temp_digits[7:0];
         3'd3:    ram_wdata = hum_digits[15:8];
         3'd4:    ram_wdata = hum_digits[7:0];
         default: ram_wdata = ASCII_ZERO;
      endcase
   end

   // Datapath controls for each state.
   always_comb begin
      cmd_pop   = (state_ff == BK_IDLE) && cmd_valid;
      cmd_in    = cmd_pop ? cmd_data : cmd_ff;
      step_in   = (state_ff == BK_FMT) ? step_ff + 3'd1 : '0;
      ram_we    = (state_ff == BK_FMT);
      ram_waddr = GROUP_BASE[cmd_ff.channel] + fmt_offset;
      ram_re    = (state_ff == BK_DUMP_RD);

      idx_in = idx_ff;
      if (state_ff == BK_IDLE) begin
         idx_in = '0;
      end else if ((state_ff == BK_DUMP_WR) && out_free) begin
         idx_in = idx_ff + 6'd1;
      end

      written_in = written_ff;
      if (ram_we) begin
         written_in[ram_waddr] = 1'b1;
      end

      rsp_load    = 1'b0;
      rsp_port_in = rsp_port_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if ((state_ff == BK_POLL) && out_free) begin
         rsp_load    = 1'b1;
         rsp_port_in = {1'b0, cmd_ff.channel};
         rsp_byte_in = poll_code;
         rsp_last_in = 1'b1;
      end else if ((state_ff == BK_DUMP_WR) && out_free) begin
         rsp_load    = 1'b1;
         rsp_port_in = UPSTREAM_PORT;
         rsp_byte_in = frame_byte;
         rsp_last_in = (idx_ff == LAST_FRAME_ADDR);
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      rsp_port_ff <= rsp_port_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (ram_re) begin
         rd_written_ff <= written_ff[idx_ff];
         rd_tmpl_ff    <= FRAME_TEMPLATE[idx_ff];
      end
   end

   // Frame memory; bytes never written read back from the template.
   spfr_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_port   = rsp_port_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

### hw/rtl/sensor_poll_frame_relay_core.sv
// Top level of the sensor poll frame relay: configuration registers and front/back wiring.
`timescale 1ns / 1ps

// Tick-driven relay for up to four sensor links. A reply beat for a configured channel
// is stored by the front end when accepted. A tick beat is taken by the front end, which
// files a command in a two-entry queue. For a poll the back end takes the command and
// loads the poll byte into the output register, first writing the five formatted reply
// bytes into the frame memory (one byte per cycle through its single write port) when a
// reply is ready. For the 42-byte frame dump at tick 100 it takes the command, then for
// each frame byte does a registered memory read and loads the output register once free.
// Ticks keep being accepted while the queue has room, and the output register lets
// the back end finish a byte while the previous one still waits to be taken.
module sensor_poll_frame_relay_core import spfr_pkg::*; #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_presence_byte,
   input  logic [7:0]  req_temperature_byte,
   input  logic [7:0]  req_humidity_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_port,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]        poll_code_ff, poll_code_in;
   logic [TICK_W-1:0] period_top_ff, period_top_in;

   logic    cmd_push;
   cmd_type cmd_push_data;
   logic    cmd_full;
   logic    cmd_pop;
   cmd_type cmd_pop_data;
   logic    cmd_valid;

   // Configuration register writes.
   always_comb begin
      poll_code_in  = poll_code_ff;
      period_top_in = period_top_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLL_CODE:  poll_code_in  = csr_wdata;
            CSR_PERIOD_TOP: period_top_in = csr_wdata[TICK_W-1:0];
            default:        poll_code_in  = poll_code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_code_ff  <= POLL_CODE_RESET;
         period_top_ff <= PERIOD_TOP_RESET;
      end else begin
         poll_code_ff  <= poll_code_in;
         period_top_ff <= period_top_in;
      end
   end

   spfr_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_channel          (req_channel),
      .req_presence_byte    (req_presence_byte),
      .req_temperature_byte (req_temperature_byte),
      .req_humidity_byte    (req_humidity_byte),
      .period_top           (period_top_ff),
      .cmd_push             (cmd_push),
      .cmd_data             (cmd_push_data),
      .cmd_full             (cmd_full)
   );

   spfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .not_empty (cmd_valid)
   );

   spfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_pop_data),
      .cmd_pop        (cmd_pop),
      .poll_code      (poll_code_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_port   (rsp_out_port),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef SYNTHESIS
   // The front end never files a command into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(cmd_push && cmd_full))
      else $error("command queue overflow");

   // Every poll beat is a single-byte message and so carries the last flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_port != UPSTREAM_PORT)) |-> rsp_frame_last)
      else $error("poll beat without last flag");

   // Nothing is offered on the result channel right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat offered right after reset");
`endif

endmodule
